/* rtl/qpsc_pkg.sv */
package qpsc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic signed [31:0] TARGET_SPEED_RST     = 32'sd205783;
  localparam logic signed [31:0] PROP_GAIN_RST        = 32'sd19005;
  localparam logic signed [31:0] INTEGRAL_GAIN_DT_RST = 32'sd5852;
  localparam logic        [30:0] COUNT_TO_SPEED_RST   = 31'd25231;

  typedef enum logic [1:0] {
    REG_TARGET_SPEED     = 2'd0,
    REG_PROP_GAIN        = 2'd1,
    REG_INTEGRAL_GAIN_DT = 2'd2,
    REG_COUNT_TO_SPEED   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] target_speed;
    logic signed [31:0] prop_gain;
    logic signed [31:0] integral_gain_dt;
    logic        [30:0] count_to_speed;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ERR,
    B_PMUL,
    B_IMUL,
    B_DONE
  } back_state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Q16.16 product rounded half up: floor((p + 2^15) / 2^16).
  function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
    logic signed [63:0] sum;
    sum = p + 64'sd32768;
    return sum[63:16];
  endfunction

endpackage

/* rtl/quadrature_pi_speed_control.sv */
// Quadrature encoder counter with a PI speed loop; speed, gains and drive
// command are signed Q16.16. The front end takes encoder edge words while the
// input is not stalled; each steps a saturating COUNT_WIDTH-bit counter. A
// sample tick word snapshots and clears the counter and drops the count
// into a two-entry queue; only ticks produce an output word. The back end
// works one tick at a time through a single shared 32x32 multiplier that it
// uses three times (speed, proportional term, integral term). Edges keep
// flowing while the back end computes; the input stalls only when two ticks
// are already queued. Configuration writes are always ready and should be
// made while idle.
module quadrature_pi_speed_control #(
  parameter int COUNT_WIDTH = qpsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic               in_edge_on_b,
  input  logic               in_level_a,
  input  logic               in_level_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_command,
  output logic signed [31:0] out_measured_speed,
  output logic signed [15:0] out_tick_delta,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import qpsc_pkg::*;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   queue_push;
  logic                   queue_pop;
  logic                   queue_full;
  logic                   queue_empty;
  logic [COUNT_WIDTH-1:0] queue_wdata;
  logic [COUNT_WIDTH-1:0] queue_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_SPEED:     cfg_nxt.target_speed     = cfg_data;
        REG_PROP_GAIN:        cfg_nxt.prop_gain        = cfg_data;
        REG_INTEGRAL_GAIN_DT: cfg_nxt.integral_gain_dt = cfg_data;
        REG_COUNT_TO_SPEED:   cfg_nxt.count_to_speed   = cfg_data[30:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed     <= TARGET_SPEED_RST;
      cfg_r.prop_gain        <= PROP_GAIN_RST;
      cfg_r.integral_gain_dt <= INTEGRAL_GAIN_DT_RST;
      cfg_r.count_to_speed   <= COUNT_TO_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qpsc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_edge_on_b (in_edge_on_b),
    .in_level_a   (in_level_a),
    .in_level_b   (in_level_b),
    .queue_full   (queue_full),
    .queue_push   (queue_push),
    .queue_data   (queue_wdata)
  );

  qpsc_fifo #(
    .WIDTH (COUNT_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (queue_push),
    .push_data (queue_wdata),
    .pop       (queue_pop),
    .pop_data  (queue_rdata),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  qpsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .queue_empty        (queue_empty),
    .queue_data         (queue_rdata),
    .queue_pop          (queue_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_command  (out_drive_command),
    .out_measured_speed (out_measured_speed),
    .out_tick_delta     (out_tick_delta)
  );

endmodule

/* rtl/qpsc_fifo.sv */
module qpsc_fifo #(
  parameter int WIDTH = qpsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import qpsc_pkg::*;

  // Two entries: two ticks can wait while the back end works on another.
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/qpsc_front.sv */
module qpsc_front #(
  parameter int COUNT_WIDTH = qpsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic                   in_edge_on_b,
  input  logic                   in_level_a,
  input  logic                   in_level_b,
  input  logic                   queue_full,
  output logic                   queue_push,
  output logic [COUNT_WIDTH-1:0] queue_data
);
  import qpsc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   accept;
  logic                   step_up;

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign queue_push = accept && in_kind;
  assign queue_data = count_r;

  // x4 decoding: an A edge counts up when the levels differ, a B edge when they match.
  assign step_up = in_edge_on_b ? (in_level_a == in_level_b) : (in_level_a != in_level_b);

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_kind) begin
        count_nxt = '0;
      end else if (step_up) begin
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (count_r != CNT_MIN) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/qpsc_back.sv */
module qpsc_back #(
  parameter int COUNT_WIDTH = qpsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qpsc_pkg::cfg_t         cfg,
  input  logic                   queue_empty,
  input  logic [COUNT_WIDTH-1:0] queue_data,
  output logic                   queue_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_drive_command,
  output logic signed [31:0]     out_measured_speed,
  output logic signed [15:0]     out_tick_delta
);
  import qpsc_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic signed [63:0]            prod_r;
  logic signed [31:0]            speed_r, speed_nxt;
  logic signed [31:0]            err_r, err_nxt;
  logic signed [31:0]            cmd_r, cmd_nxt;
  logic signed [31:0]            integ_r, integ_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [31:0]            out_cmd_r, out_cmd_nxt;
  logic signed [31:0]            out_speed_r, out_speed_nxt;
  logic signed [15:0]            out_delta_r, out_delta_nxt;

  // One shared multiplier, operands picked by the sequencer step.
  logic signed [31:0]            mul_a, mul_b;
  logic signed [31:0]            head_ext;
  logic signed [31:0]            cnt_ext;
  logic signed [63:0]            err_wide;
  logic signed [63:0]            acc_wide;
  logic                          out_free;

  assign head_ext = 32'(signed'(queue_data));
  assign cnt_ext  = 32'(cnt_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      B_PMUL: begin
        mul_a = cfg.prop_gain;
        mul_b = err_r;
      end
      // The integral product is kept in place while the result waits.
      B_IMUL, B_DONE: begin
        mul_a = cfg.integral_gain_dt;
        mul_b = err_r;
      end
      default: begin
        mul_a = head_ext;
        mul_b = signed'({1'b0, cfg.count_to_speed});
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    queue_pop     = 1'b0;
    cnt_nxt       = cnt_r;
    speed_nxt     = speed_r;
    err_nxt       = err_r;
    cmd_nxt       = cmd_r;
    integ_nxt     = integ_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cmd_nxt   = out_cmd_r;
    out_speed_nxt = out_speed_r;
    out_delta_nxt = out_delta_r;
    err_wide      = 64'(speed_r);
    acc_wide      = 64'(integ_r);

    unique case (state_r)
      B_IDLE: begin
        if (!queue_empty) begin
          queue_pop = 1'b1;
          cnt_nxt   = queue_data;
          state_nxt = B_ERR;
        end
      end
      B_ERR: begin
        // The count is an integer, so the speed product is already Q16.16.
        speed_nxt = sat32(prod_r);
        err_wide  = 64'(cfg.target_speed) - 64'(sat32(prod_r));
        err_nxt   = sat32(err_wide);
        state_nxt = B_PMUL;
      end
      B_PMUL: begin
        state_nxt = B_IMUL;
      end
      B_IMUL: begin
        acc_wide  = 64'(round_q16(prod_r)) + 64'(integ_r);
        cmd_nxt   = sat32(acc_wide);
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          acc_wide      = 64'(integ_r) + 64'(round_q16(prod_r));
          integ_nxt     = sat32(acc_wide);
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = cmd_r;
          out_speed_nxt = speed_r;
          if (cnt_ext > 32'sd32767) begin
            out_delta_nxt = 16'sh7FFF;
          end else if (cnt_ext < -32'sd32768) begin
            out_delta_nxt = 16'sh8000;
          end else begin
            out_delta_nxt = cnt_ext[15:0];
          end
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    cnt_r       <= cnt_nxt;
    speed_r     <= speed_nxt;
    err_r       <= err_nxt;
    cmd_r       <= cmd_nxt;
    out_cmd_r   <= out_cmd_nxt;
    out_speed_r <= out_speed_nxt;
    out_delta_r <= out_delta_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_drive_command  = out_cmd_r;
  assign out_measured_speed = out_speed_r;
  assign out_tick_delta     = out_delta_r;

endmodule
